FILE: rtl/core/tli_pkg.sv
// Shared types and constants for the table linear interpolation block.
// No dependencies.
`default_nettype none
package tli_pkg;
	localparam int MaxPoints = 1024;
	localparam int IdxW = $clog2(MaxPoints);
	localparam int CntW = IdxW + 1;

	localparam logic [1:0] StatOk    = 2'd0;
	localparam logic [1:0] StatBelow = 2'd1;
	localparam logic [1:0] StatBeyond = 2'd2;
	localparam logic [1:0] StatZero  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_FETCH, ST_WAIT, ST_MUL, ST_DIV, ST_FIN, ST_OUT
	} state_t;
endpackage
`default_nettype wire

FILE: rtl/core/table_linear_interpolation_top.sv
// Top level of the table linear interpolation block: table memories,
// scan, multiply, serial divide. Depends on tli_pkg.
// A write (tuser low) stores one entry; a query (tuser high) scans the n points in
// use, one memory read per cycle during the scan, fetches the best entry and the next,
// then a 64-step restoring divider forms the value. The next item is taken only after
// the result word has been accepted at the output. One item at a time.
// Reset clears control state and points_in_use; table contents are
// undefined until written, no clearing pass.
`default_nettype none
module table_linear_interpolation_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [10:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// tdata: entry_index[9:0], point_time[41:10], point_value[73:42], query_time[105:74]
	input  wire logic [111:0] s_tdata,
	// tuser: kind
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// tdata: interp_value[31:0], status[33:32]
	output logic [39:0]      m_tdata
);
	import tli_pkg::*;

	logic [31:0] times_mem [MaxPoints];
	logic [31:0] vals_mem  [MaxPoints];
	logic [31:0] rd_t, rd_v;
	logic [IdxW-1:0] rd_addr;

	state_t st_q, st_d;
	logic [CntW-1:0] n_q, pts_q, scan_q;
	logic [IdxW-1:0] best_q;
	logic found_q, rdv_q, fetch1_q;
	logic [31:0] dist_q, q_q, t0_q, y0_q;
	logic [IdxW-1:0] rdidx_q;
	logic [63:0] rem_q, quot_q, adt_q;
	logic [32:0] a_q, ady_q;
	logic neg_q;
	logic [6:0] dcnt_q;
	logic [31:0] res_val_q;
	logic [1:0] res_stat_q;

	wire in_acc = s_tvalid && s_tready;
	wire [IdxW-1:0] w_idx = s_tdata[9:0];

	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = (st_q == ST_OUT);
	assign m_tdata  = {6'd0, res_stat_q, res_val_q};

	// memory address: scan pointer, best in the first fetch cycle, then best+1
	// held through the wait cycle so the next entry is on rd_t in ST_MUL
	always_comb begin
		rd_addr = scan_q[IdxW-1:0];
		if (st_q == ST_FETCH && !fetch1_q) rd_addr = best_q;
		else if (st_q == ST_FETCH || st_q == ST_WAIT) rd_addr = best_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (in_acc && !s_tuser) begin
			times_mem[w_idx] <= s_tdata[41:10];
			vals_mem[w_idx]  <= s_tdata[73:42];
		end
		rd_t <= times_mem[rd_addr];
		rd_v <= vals_mem[rd_addr];
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:  if (in_acc && s_tuser) st_d = ST_SCAN;
			ST_SCAN:  if (scan_q >= n_q && !rdv_q) st_d = ST_FETCH;
			ST_FETCH: if (fetch1_q) st_d = ST_WAIT;
			ST_WAIT:  st_d = ST_MUL;
			ST_MUL:   st_d = ST_DIV;
			ST_DIV:   if (dcnt_q == 7'd0) st_d = ST_FIN;
			ST_FIN:   st_d = ST_OUT;
			ST_OUT:   if (m_tready) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	wire [63:0] rem_sh = {rem_q[62:0], quot_q[63]};
	wire [64:0] rem_sub = {1'b0, rem_sh} - {1'b0, adt_q};
	wire signed [33:0] dt_s = $signed({2'b0, rd_t}) - $signed({2'b0, t0_q});
	wire signed [33:0] dy_s = $signed({{2{rd_v[31]}}, rd_v}) - $signed({{2{y0_q[31]}}, y0_q});
	wire signed [35:0] res_s = neg_q ? $signed({{4{y0_q[31]}}, y0_q}) - $signed({1'b0, quot_q[34:0]})
	                                 : $signed({{4{y0_q[31]}}, y0_q}) + $signed({1'b0, quot_q[34:0]});
	wire last_best = ({1'b0, best_q} + 1'b1) >= n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			pts_q <= '0;
			rdv_q <= 1'b0;
			fetch1_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) pts_q <= cfg_wdata;
			rdv_q <= (st_q == ST_SCAN) && (scan_q < n_q);
			if (st_q == ST_FETCH) fetch1_q <= !fetch1_q;
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				q_q <= s_tdata[105:74];
				n_q <= (pts_q > CntW'(MaxPoints)) ? CntW'(MaxPoints) : pts_q;
				scan_q <= '0;
				found_q <= 1'b0;
				best_q <= '0;
			end
			ST_SCAN: begin
				if (scan_q < n_q) scan_q <= scan_q + 1'b1;
				rdidx_q <= scan_q[IdxW-1:0];
				// compare the entry read last cycle; strict less keeps first on tie
				if (rdv_q && rd_t <= q_q && (!found_q || (q_q - rd_t) < dist_q)) begin
					found_q <= 1'b1;
					dist_q <= q_q - rd_t;
					best_q <= rdidx_q;
				end
			end
			ST_FETCH: begin
				// best entry data arrives in the second fetch cycle
				if (fetch1_q) begin
					t0_q <= rd_t;
					y0_q <= rd_v;
				end
			end
			ST_WAIT: ;
			ST_MUL: begin
				// next entry data arrives now
				adt_q <= {30'd0, dt_s[33] ? -dt_s : dt_s};
				ady_q <= 33'(dy_s[33] ? -dy_s : dy_s);
				neg_q <= dy_s[33] != dt_s[33];
				a_q <= {1'b0, q_q - t0_q};
				res_stat_q <= !found_q ? StatBelow : last_best ?
					((t0_q == q_q) ? StatOk : StatBeyond) :
					(dt_s == 0 ? StatZero : StatOk);
				dcnt_q <= 7'd64;
			end
			ST_DIV: begin
				if (dcnt_q == 7'd64) begin
					quot_q <= 64'(a_q * ady_q);
					rem_q <= '0;
				end else begin
					rem_q <= rem_sub[64] ? rem_sh : rem_sub[63:0];
					quot_q <= {quot_q[62:0], ~rem_sub[64]};
				end
				dcnt_q <= dcnt_q - 1'b1;
			end
			ST_FIN: begin
				if (res_stat_q != StatOk) res_val_q <= '0;
				else if (!found_q || last_best) res_val_q <= y0_q;
				else if (quot_q > 64'h2_0000_0000 || res_s > 36'sh7FFF_FFFF)
					res_val_q <= neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
				else if (res_s < -36'sh8000_0000) res_val_q <= 32'h8000_0000;
				else res_val_q <= res_s[31:0];
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	// last_best: on the last entry y0 holds the chosen value
	assert property (@(posedge clk) disable iff (!arst_n) m_tvalid |-> !s_tready)
		else $error("input taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FIN) |=> (res_stat_q == StatOk || res_val_q == '0))
		else $error("nonzero value with error status");
endmodule
`default_nettype wire
